### design/modbus_rtu_frame_crc_core_assert.svh
// Assertion macros for the Modbus RTU frame CRC core.
// MBCRC_ASSERT checks that a property holds; MBCRC_NEVER checks that an expression is never true.
`ifndef MODBUS_RTU_FRAME_CRC_CORE_ASSERT_SVH
`define MODBUS_RTU_FRAME_CRC_CORE_ASSERT_SVH
`ifndef SYNTHESIS
`define MBCRC_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define MBCRC_NEVER(lbl, clk, rst_n, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);
`else
`define MBCRC_ASSERT(lbl, clk, rst_n, prop, msg)
`define MBCRC_NEVER(lbl, clk, rst_n, expr, msg)
`endif
`endif

### design/mbcrc_pkg.sv
package mbcrc_pkg;

    localparam logic [15:0] CRC_INIT       = 16'hFFFF;
    localparam logic [15:0] CRC_POLY       = 16'hA001;
    localparam logic [7:0]  BROADCAST_ADDR = 8'h00;
    localparam logic [7:0]  OWN_ADDR_RESET = 8'h01;

    // register index (byte address / 4)
    localparam logic REG_OWN_ADDRESS = 1'b0;

    // status codes of a result
    localparam logic [1:0] STAT_BYTE     = 2'd0;
    localparam logic [1:0] STAT_ACCEPTED = 2'd1;
    localparam logic [1:0] STAT_CRC_ERR  = 2'd2;
    localparam logic [1:0] STAT_NOT_ADDR = 2'd3;

    // kind of work handed from front to back
    typedef enum logic [1:0] {
        JOB_BYTE       = 2'd0,
        JOB_SEND_LAST  = 2'd1,
        JOB_CHECK_LAST = 2'd2
    } t_job_kind;

    typedef struct packed {
        t_job_kind   kind;
        logic [7:0]  data_byte;
        logic [15:0] crc;
        logic [1:0]  status;
    } t_job;

    // output sequencer states
    typedef enum logic [2:0] {
        EMIT_DATA   = 3'b001,
        EMIT_CRC_LO = 3'b010,
        EMIT_CRC_HI = 3'b100
    } t_emit_state;

    // byte-wide CRC-16/MODBUS update, reflected
    function automatic logic [15:0] crc_update(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {8'h00, b};
        for (int k = 0; k < 8; k++) begin
            if (c[0]) begin
                c = (c >> 1) ^ CRC_POLY;
            end else begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

endpackage

### design/mbcrc_if.sv
interface mbcrc_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       frame_end;
    logic       operation;

    modport source (output valid, data_byte, frame_end, operation, input ready);
    modport sink (input valid, data_byte, frame_end, operation, output ready);
endinterface

interface mbcrc_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       out_last;
    logic [1:0] status;

    modport source (output valid, out_byte, out_last, status, input ready);
    modport sink (input valid, out_byte, out_last, status, output ready);
endinterface

### design/mbcrc_front.sv
module mbcrc_front (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic [7:0]           i_own_address,
    input  logic                 i_queue_full,
    mbcrc_in_if.sink             i_in,
    output logic                 o_push,
    output mbcrc_pkg::t_job      o_job
);

    logic [15:0] r_crc, n_crc;
    logic [7:0]  r_held0, n_held0;
    logic [7:0]  r_held1, n_held1;
    logic [1:0]  r_cnt, n_cnt;
    logic [7:0]  r_addr, n_addr;

    logic        accept;
    logic        check;
    logic        crc_apply;
    logic [7:0]  crc_byte;
    logic [15:0] crc_new;
    logic [7:0]  addr_new;
    logic [15:0] rx_crc;
    logic [1:0]  chk_status;

    assign i_in.ready = !i_queue_full;
    assign accept     = i_in.valid && !i_queue_full;
    assign check      = i_in.operation;

    // check mode folds in the byte two places back; the last two are the CRC
    assign crc_byte  = check ? r_held0 : i_in.data_byte;
    assign crc_apply = !check || (r_cnt >= 2'd2);
    assign crc_new   = crc_apply ? mbcrc_pkg::crc_update(r_crc, crc_byte) : r_crc;
    assign addr_new  = (r_cnt == 2'd0) ? i_in.data_byte : r_addr;
    assign rx_crc    = {i_in.data_byte, r_held1};

    always_comb begin
        if (r_cnt < 2'd2) begin
            chk_status = mbcrc_pkg::STAT_CRC_ERR;
        end else if (rx_crc != crc_new) begin
            chk_status = mbcrc_pkg::STAT_CRC_ERR;
        end else if (addr_new != i_own_address && addr_new != mbcrc_pkg::BROADCAST_ADDR) begin
            chk_status = mbcrc_pkg::STAT_NOT_ADDR;
        end else begin
            chk_status = mbcrc_pkg::STAT_ACCEPTED;
        end
    end

    always_comb begin
        o_job.data_byte = i_in.data_byte;
        o_job.crc       = crc_new;
        o_job.status    = chk_status;
        if (check) begin
            o_job.kind = mbcrc_pkg::JOB_CHECK_LAST;
        end else if (i_in.frame_end) begin
            o_job.kind = mbcrc_pkg::JOB_SEND_LAST;
        end else begin
            o_job.kind = mbcrc_pkg::JOB_BYTE;
        end
    end

    // check-mode bytes before the last produce nothing
    assign o_push = accept && !(check && !i_in.frame_end);

    always_comb begin
        n_crc   = r_crc;
        n_held0 = r_held0;
        n_held1 = r_held1;
        n_cnt   = r_cnt;
        n_addr  = r_addr;
        if (accept) begin
            if (i_in.frame_end) begin
                n_crc   = mbcrc_pkg::CRC_INIT;
                n_held0 = 8'h00;
                n_held1 = 8'h00;
                n_cnt   = 2'd0;
                n_addr  = 8'h00;
            end else begin
                n_crc  = crc_new;
                n_addr = addr_new;
                n_cnt  = (r_cnt == 2'd3) ? 2'd3 : r_cnt + 2'd1;
                if (check) begin
                    n_held0 = r_held1;
                    n_held1 = i_in.data_byte;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_crc   <= mbcrc_pkg::CRC_INIT;
            r_held0 <= 8'h00;
            r_held1 <= 8'h00;
            r_cnt   <= 2'd0;
            r_addr  <= 8'h00;
        end else begin
            r_crc   <= n_crc;
            r_held0 <= n_held0;
            r_held1 <= n_held1;
            r_cnt   <= n_cnt;
            r_addr  <= n_addr;
        end
    end

endmodule

### design/mbcrc_fifo.sv
module mbcrc_fifo #(
    parameter int DEPTH = 2
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_push,
    input  mbcrc_pkg::t_job      i_job,
    input  logic                 i_pop,
    output mbcrc_pkg::t_job      o_head,
    output logic                 o_empty,
    output logic                 o_full
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    mbcrc_pkg::t_job  r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr, n_wr;
    logic [PTR_W-1:0] r_rd, n_rd;
    logic [CNT_W-1:0] r_cnt, n_cnt;

    assign o_empty = (r_cnt == '0);
    assign o_full  = (r_cnt == CNT_W'(DEPTH));
    assign o_head  = r_mem[r_rd];

    always_comb begin
        n_wr  = r_wr;
        n_rd  = r_rd;
        n_cnt = r_cnt;
        if (i_push) begin
            n_wr = (r_wr == PTR_W'(DEPTH - 1)) ? '0 : r_wr + PTR_W'(1);
        end
        if (i_pop) begin
            n_rd = (r_rd == PTR_W'(DEPTH - 1)) ? '0 : r_rd + PTR_W'(1);
        end
        case ({i_push, i_pop})
            2'b10:   n_cnt = r_cnt + CNT_W'(1);
            2'b01:   n_cnt = r_cnt - CNT_W'(1);
            default: n_cnt = r_cnt;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

endmodule

### design/mbcrc_back.sv
module mbcrc_back (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  mbcrc_pkg::t_job      i_head,
    input  logic                 i_head_valid,
    output logic                 o_pop,
    mbcrc_out_if.source          o_out
);

    mbcrc_pkg::t_emit_state r_state, n_state;
    logic       r_valid, n_valid;
    logic [7:0] r_byte, n_byte;
    logic       r_last, n_last;
    logic [1:0] r_status, n_status;
    logic       load;

    assign load = !r_valid || o_out.ready;

    always_comb begin
        n_state  = r_state;
        n_valid  = r_valid;
        n_byte   = r_byte;
        n_last   = r_last;
        n_status = r_status;
        o_pop    = 1'b0;
        if (load) begin
            n_valid = 1'b0;
            case (r_state)
                mbcrc_pkg::EMIT_DATA: begin
                    if (i_head_valid) begin
                        n_valid = 1'b1;
                        case (i_head.kind)
                            mbcrc_pkg::JOB_SEND_LAST: begin
                                n_byte   = i_head.data_byte;
                                n_last   = 1'b0;
                                n_status = mbcrc_pkg::STAT_BYTE;
                                n_state  = mbcrc_pkg::EMIT_CRC_LO;
                            end
                            mbcrc_pkg::JOB_CHECK_LAST: begin
                                n_byte   = 8'h00;
                                n_last   = 1'b1;
                                n_status = i_head.status;
                                o_pop    = 1'b1;
                            end
                            default: begin
                                n_byte   = i_head.data_byte;
                                n_last   = 1'b0;
                                n_status = mbcrc_pkg::STAT_BYTE;
                                o_pop    = 1'b1;
                            end
                        endcase
                    end
                end
                mbcrc_pkg::EMIT_CRC_LO: begin
                    n_valid  = 1'b1;
                    n_byte   = i_head.crc[7:0];
                    n_last   = 1'b0;
                    n_status = mbcrc_pkg::STAT_BYTE;
                    n_state  = mbcrc_pkg::EMIT_CRC_HI;
                end
                mbcrc_pkg::EMIT_CRC_HI: begin
                    n_valid  = 1'b1;
                    n_byte   = i_head.crc[15:8];
                    n_last   = 1'b1;
                    n_status = mbcrc_pkg::STAT_BYTE;
                    n_state  = mbcrc_pkg::EMIT_DATA;
                    o_pop    = 1'b1;
                end
                default: begin
                    n_state = mbcrc_pkg::EMIT_DATA;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= mbcrc_pkg::EMIT_DATA;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_byte   <= n_byte;
        r_last   <= n_last;
        r_status <= n_status;
    end

    assign o_out.valid    = r_valid;
    assign o_out.out_byte = r_byte;
    assign o_out.out_last = r_last;
    assign o_out.status   = r_status;

endmodule

### design/modbus_rtu_frame_crc_core.sv
// Modbus RTU frame CRC core (CRC-16/MODBUS, reflected poly 0xA001, init 0xFFFF). Frame bytes
// come in one per input transaction, address byte first, frame_end on the last. operation 0
// (send): each byte goes straight out, and the last byte is followed by the CRC low then high
// byte, the high byte flagged out_last. operation 1 (check): bytes are consumed silently, the
// last two taken as the received CRC, and one result at frame end gives status accepted, CRC
// error (also for frames under three bytes, and checked before the address) or not addressed
// here (first byte neither own_address nor broadcast 0). The front stage takes one byte per
// cycle, stalling only when the queue is full, with a byte-wide CRC update; results wait in a
// QUEUE_DEPTH-entry queue, then an output register. The back sequencer gives one output
// transaction per cycle while the receiver is ready, so a send-mode last byte costs three
// output transactions. own_address sits at APB byte address 0 (reset 1); the user must write it
// only while the core is idle, which the core does not enforce. No clearing pass after reset.
`include "modbus_rtu_frame_crc_core_assert.svh"

module modbus_rtu_frame_crc_core #(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    mbcrc_in_if.sink     i_in_ch,
    mbcrc_out_if.source  o_out_ch,
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [2:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready
);

    // --- configuration: own station address ---
    logic [7:0] r_own_address;
    logic       cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == mbcrc_pkg::REG_OWN_ADDRESS);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_own_address <= mbcrc_pkg::OWN_ADDR_RESET;
        end else if (cfg_wr) begin
            r_own_address <= pwdata[7:0];
        end
    end

    assign prdata = (paddr[2] == mbcrc_pkg::REG_OWN_ADDRESS) ? {24'h000000, r_own_address}
                                                             : 32'h00000000;

    // --- front: frame state, CRC, outcome classification ---
    logic            s_push;
    logic            s_pop;
    logic            s_full;
    logic            s_empty;
    mbcrc_pkg::t_job s_job;
    mbcrc_pkg::t_job s_head;

    mbcrc_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_own_address (r_own_address),
        .i_queue_full  (s_full),
        .i_in          (i_in_ch),
        .o_push        (s_push),
        .o_job         (s_job)
    );

    // --- queue between front and back ---
    mbcrc_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (s_push),
        .i_job   (s_job),
        .i_pop   (s_pop),
        .o_head  (s_head),
        .o_empty (s_empty),
        .o_full  (s_full)
    );

    // --- back: output sequencer, one result per cycle while the receiver is ready ---
    mbcrc_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_head       (s_head),
        .i_head_valid (!s_empty),
        .o_pop        (s_pop),
        .o_out        (o_out_ch)
    );

    // --- checks ---
    `MBCRC_NEVER(a_push_full, i_clk, i_rst_n, s_push && s_full, "push into full queue")
    `MBCRC_NEVER(a_pop_empty, i_clk, i_rst_n, s_pop && s_empty, "pop from empty queue")
    `MBCRC_ASSERT(a_outcome_form, i_clk, i_rst_n, (o_out_ch.valid && o_out_ch.status != mbcrc_pkg::STAT_BYTE) |-> (o_out_ch.out_last && o_out_ch.out_byte == 8'h00), "outcome result malformed")

endmodule

### bench/tb_modbus_rtu_frame_crc_core.sv
module tb_modbus_rtu_frame_crc_core;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int ITEMS_PER_PHASE = 42;
    localparam int NUM_PHASES      = 5;
    localparam int HOLD_CYCLES     = 60;    // long receiver hold-off, fills the core's queue
    localparam int SETTLE_CYCLES   = 8;     // margin for the core's queue and output register to drain
    localparam int DRAIN_LIMIT     = 1000;
    localparam int STALL_LIMIT     = 2000;  // cycles without any accepted transaction
    localparam int MAX_REPORTS     = 10;

    localparam logic [2:0] ADDR_OWN      = {mbcrc_pkg::REG_OWN_ADDRESS, 2'b00};
    localparam logic [2:0] ADDR_UNMAPPED = 3'b100;   // register index 1 does not exist

    typedef enum logic {
        OP_SEND  = 1'b0,
        OP_CHECK = 1'b1
    } t_op;

    typedef enum int {
        FR_GOOD_CHECK,
        FR_SEND,
        FR_NOISE
    } t_frame_kind;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
        t_op        op;
    } t_rtu_byte;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
        logic [1:0] status;
    } t_rtu_result;

    // directed row: one input byte, and where pinned the outcome typed in by hand
    typedef struct packed {
        logic [7:0] data;
        logic       last;
        t_op        op;
        logic       pinned;
        logic [1:0] status;
    } t_dir_row;

    // Directed bytes. The two eight-byte frames are the well-known read-request examples
    // with their CRC already appended; own address is still 1 from reset here.
    localparam t_dir_row DIR_ROWS [24] = '{
        // one-byte frame: too short, CRC error
        '{8'h01, 1'b1, OP_CHECK, 1'b1, mbcrc_pkg::STAT_CRC_ERR},
        // two-byte frame: still too short
        '{8'h01, 1'b0, OP_CHECK, 1'b0, mbcrc_pkg::STAT_BYTE},
        '{8'h02, 1'b1, OP_CHECK, 1'b1, mbcrc_pkg::STAT_CRC_ERR},
        // good frame to station 1
        '{8'h01, 1'b0, OP_CHECK, 1'b0, mbcrc_pkg::STAT_BYTE},
        '{8'h03, 1'b0, OP_CHECK, 1'b0, mbcrc_pkg::STAT_BYTE},
        '{8'h00, 1'b0, OP_CHECK, 1'b0, mbcrc_pkg::STAT_BYTE},
        '{8'h00, 1'b0, OP_CHECK, 1'b0, mbcrc_pkg::STAT_BYTE},
        '{8'h00, 1'b0, OP_CHECK, 1'b0, mbcrc_pkg::STAT_BYTE},
        '{8'h01, 1'b0, OP_CHECK, 1'b0, mbcrc_pkg::STAT_BYTE},
        '{8'h84, 1'b0, OP_CHECK, 1'b0, mbcrc_pkg::STAT_BYTE},
        '{8'h0A, 1'b1, OP_CHECK, 1'b1, mbcrc_pkg::STAT_ACCEPTED},
        // good frame to station 0x11: not addressed here
        '{8'h11, 1'b0, OP_CHECK, 1'b0, mbcrc_pkg::STAT_BYTE},
        '{8'h03, 1'b0, OP_CHECK, 1'b0, mbcrc_pkg::STAT_BYTE},
        '{8'h00, 1'b0, OP_CHECK, 1'b0, mbcrc_pkg::STAT_BYTE},
        '{8'h6B, 1'b0, OP_CHECK, 1'b0, mbcrc_pkg::STAT_BYTE},
        '{8'h00, 1'b0, OP_CHECK, 1'b0, mbcrc_pkg::STAT_BYTE},
        '{8'h03, 1'b0, OP_CHECK, 1'b0, mbcrc_pkg::STAT_BYTE},
        '{8'h76, 1'b0, OP_CHECK, 1'b0, mbcrc_pkg::STAT_BYTE},
        '{8'h87, 1'b1, OP_CHECK, 1'b1, mbcrc_pkg::STAT_NOT_ADDR},
        // send frame with extreme bytes
        '{8'h00, 1'b0, OP_SEND,  1'b0, mbcrc_pkg::STAT_BYTE},
        '{8'hFF, 1'b1, OP_SEND,  1'b0, mbcrc_pkg::STAT_BYTE},
        // operation bit flipping within one frame
        '{8'h11, 1'b0, OP_SEND,  1'b0, mbcrc_pkg::STAT_BYTE},
        '{8'h22, 1'b0, OP_CHECK, 1'b0, mbcrc_pkg::STAT_BYTE},
        '{8'hA5, 1'b1, OP_CHECK, 1'b0, mbcrc_pkg::STAT_BYTE}
    };

    localparam logic [7:0] STATION_SET [NUM_PHASES] = '{8'h00, 8'hFF, 8'h11, 8'h80, 8'h00};

    logic        i_clk   = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    mbcrc_in_if  in_ch ();
    mbcrc_out_if out_ch ();

    modbus_rtu_frame_crc_core u_top (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_in_ch  (in_ch),
        .o_out_ch (out_ch),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Frame predictor: own copy of the station address and frame state
    // ------------------------------------------------------------------
    logic [7:0]  station_addr;
    logic [15:0] run_crc;
    logic [7:0]  held_rx [2];      // two most recent check-mode bytes, oldest first
    logic [1:0]  frame_len;        // saturates at 3
    logic [7:0]  frame_addr;

    t_rtu_result step_results [$];     // results caused by the byte just accepted
    t_rtu_result pending_results [$];  // results still to come out of the core
    t_rtu_byte   frame_bytes [$];

    // control shared between the stimulus and the receiver
    logic calm     = 1'b0;   // no idle cycles on either side
    logic hold_req = 1'b0;   // ask the receiver for one long hold-off

    int n_bytes;
    int n_results;
    int n_accepted;
    int n_crc_err;
    int n_not_addr;
    int n_bad;          // result mismatches and unexpected results
    int n_other_fail;   // register read-back errors and results that never came
    int quiet_cycles;

    // bit-serial form of the reflected CRC-16 update
    function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        logic        fb;
        c = crc;
        for (int i = 0; i < 8; i++) begin
            fb = c[0] ^ b[i];
            c  = {1'b0, c[15:1]} ^ (fb ? mbcrc_pkg::CRC_POLY : 16'h0000);
        end
        return c;
    endfunction

    task automatic clear_frame_state();
        run_crc    = mbcrc_pkg::CRC_INIT;
        held_rx[0] = 8'h00;
        held_rx[1] = 8'h00;
        frame_len  = 2'd0;
        frame_addr = 8'h00;
    endtask

    // advance the frame state by one byte and list the results it causes
    task automatic predict_byte(input t_rtu_byte it);
        logic [1:0]  prior;
        logic [1:0]  st;
        logic [15:0] rx_crc;
        prior = frame_len;
        step_results.delete();
        if (prior == 2'd0) begin
            frame_addr = it.data;
        end
        if (frame_len != 2'd3) begin
            frame_len = frame_len + 2'd1;
        end
        if (it.op == OP_SEND) begin
            // send: byte passes through, CRC low then high after the last one
            run_crc = crc16_byte(run_crc, it.data);
            step_results.push_back(t_rtu_result'{it.data, 1'b0, mbcrc_pkg::STAT_BYTE});
            if (it.last) begin
                step_results.push_back(t_rtu_result'{run_crc[7:0], 1'b0, mbcrc_pkg::STAT_BYTE});
                step_results.push_back(t_rtu_result'{run_crc[15:8], 1'b1, mbcrc_pkg::STAT_BYTE});
                clear_frame_state();
            end
        end else begin
            // check: the CRC trails two bytes behind, the last two being the received CRC
            if (prior >= 2'd2) begin
                run_crc = crc16_byte(run_crc, held_rx[0]);
            end
            held_rx[0] = held_rx[1];
            held_rx[1] = it.data;
            if (it.last) begin
                rx_crc = {held_rx[1], held_rx[0]};
                if (prior < 2'd2 || rx_crc != run_crc) begin
                    st = mbcrc_pkg::STAT_CRC_ERR;  // short frame or mismatch, before address
                end else if (frame_addr != station_addr &&
                             frame_addr != mbcrc_pkg::BROADCAST_ADDR) begin
                    st = mbcrc_pkg::STAT_NOT_ADDR;
                end else begin
                    st = mbcrc_pkg::STAT_ACCEPTED;
                end
                step_results.push_back(t_rtu_result'{8'h00, 1'b1, st});
                clear_frame_state();
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Input side: valid and payload change on the falling edge, the
    // transaction is taken at the rising edge where ready is high
    // ------------------------------------------------------------------
    task automatic offer_byte(input t_rtu_byte it, input logic pinned, input t_rtu_result want);
        int gap;
        gap = calm ? 0 : $urandom_range(0, 9);
        repeat (gap) begin
            @(negedge i_clk);
            in_ch.valid = 1'b0;
        end
        @(negedge i_clk);
        in_ch.valid     = 1'b1;
        in_ch.data_byte = it.data;
        in_ch.frame_end = it.last;
        in_ch.operation = it.op;
        do @(posedge i_clk); while (!in_ch.ready);
        n_bytes++;
        predict_byte(it);
        if (pinned) begin
            pending_results.push_back(want);
        end else begin
            foreach (step_results[k]) pending_results.push_back(step_results[k]);
        end
    endtask

    // ------------------------------------------------------------------
    // Configuration port
    // ------------------------------------------------------------------
    task automatic apb_access(input logic wr, input logic [2:0] addr, input logic [31:0] wdata,
                              output logic [31:0] rdata);
        @(negedge i_clk);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = wr;
        paddr   = addr;
        pwdata  = wdata;
        @(negedge i_clk);
        penable = 1'b1;
        do @(posedge i_clk); while (!pready);
        rdata = prdata;
        @(negedge i_clk);
        psel    = 1'b0;
        penable = 1'b0;
    endtask

    // write a register, then read the station address back
    task automatic program_station(input logic [2:0] where, input logic [7:0] value);
        logic [31:0] rd;
        apb_access(1'b1, where, {24'($urandom), value}, rd);
        if (where == ADDR_OWN) begin
            station_addr = value;
        end
        apb_access(1'b0, ADDR_OWN, 32'h0, rd);
        if (rd[7:0] !== station_addr) begin
            n_other_fail++;
            $display("own_address read back %02h, expected %02h", rd[7:0], station_addr);
        end
    endtask

    // drop valid, wait for every outstanding result, then let the pipeline go quiet
    task automatic settle_block();
        int w;
        @(negedge i_clk);
        in_ch.valid = 1'b0;
        for (w = 0; w < DRAIN_LIMIT && pending_results.size() != 0; w++) begin
            @(posedge i_clk);
        end
        if (pending_results.size() != 0) begin
            n_other_fail += pending_results.size();
            $display("%0d results never arrived", pending_results.size());
            pending_results.delete();
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // ------------------------------------------------------------------
    // Random frames
    // ------------------------------------------------------------------
    task automatic build_frame(input t_frame_kind kind);
        int          len;
        int          pick;
        int          idx;
        logic [7:0]  b;
        logic [15:0] crc;
        frame_bytes.delete();
        case (kind)
            FR_GOOD_CHECK: begin
                // own, broadcast or foreign station, 0..5 payload bytes, correct CRC
                pick = $urandom_range(0, 2);
                b    = (pick == 0) ? station_addr :
                       (pick == 1) ? mbcrc_pkg::BROADCAST_ADDR : 8'($urandom);
                len  = $urandom_range(0, 5);
                crc  = mbcrc_pkg::CRC_INIT;
                frame_bytes.push_back(t_rtu_byte'{b, 1'b0, OP_CHECK});
                crc = crc16_byte(crc, b);
                repeat (len) begin
                    b = 8'($urandom);
                    frame_bytes.push_back(t_rtu_byte'{b, 1'b0, OP_CHECK});
                    crc = crc16_byte(crc, b);
                end
                frame_bytes.push_back(t_rtu_byte'{crc[7:0], 1'b0, OP_CHECK});
                frame_bytes.push_back(t_rtu_byte'{crc[15:8], 1'b0, OP_CHECK});
                // a quarter of them get one bit flipped somewhere, address and CRC included
                if ($urandom_range(0, 3) == 0) begin
                    idx = $urandom_range(0, frame_bytes.size() - 1);
                    frame_bytes[idx].data = frame_bytes[idx].data ^ 8'(1 << $urandom_range(0, 7));
                end
            end
            FR_SEND: begin
                len = $urandom_range(1, 8);
                repeat (len) frame_bytes.push_back(t_rtu_byte'{8'($urandom), 1'b0, OP_SEND});
            end
            default: begin
                // short or mixed-operation noise
                len = $urandom_range(1, 5);
                repeat (len) begin
                    frame_bytes.push_back(
                        t_rtu_byte'{8'($urandom), 1'b0, t_op'($urandom_range(0, 1))});
                end
            end
        endcase
        frame_bytes[frame_bytes.size() - 1].last = 1'b1;
    endtask

    // ------------------------------------------------------------------
    // Output side: random stalls per transaction, one long hold-off on request
    // ------------------------------------------------------------------
    initial begin
        int          stall;
        logic        hold_done;
        t_rtu_result got;
        t_rtu_result want;
        out_ch.ready = 1'b0;
        hold_done    = 1'b0;
        wait (i_rst_n);
        forever begin
            if (hold_req && !hold_done) begin
                hold_done = 1'b1;
                repeat (HOLD_CYCLES) begin
                    @(negedge i_clk);
                    out_ch.ready = 1'b0;
                end
            end
            stall = calm ? 0 : $urandom_range(0, 9);
            repeat (stall) begin
                @(negedge i_clk);
                out_ch.ready = 1'b0;
            end
            @(negedge i_clk);
            out_ch.ready = 1'b1;
            do @(posedge i_clk); while (!out_ch.valid);
            got = t_rtu_result'{out_ch.out_byte, out_ch.out_last, out_ch.status};
            n_results++;
            if (pending_results.size() == 0) begin
                n_bad++;
                if (n_bad <= MAX_REPORTS) begin
                    $display("unexpected result: byte %02h last %0b status %0d",
                             got.data, got.last, got.status);
                end
            end else begin
                want = pending_results.pop_front();
                if (got !== want) begin
                    n_bad++;
                    if (n_bad <= MAX_REPORTS) begin
                        $display("result %0d: expected byte %02h last %0b status %0d, got %02h %0b %0d",
                                 n_results, want.data, want.last, want.status,
                                 got.data, got.last, got.status);
                    end
                end
                case (want.status)
                    mbcrc_pkg::STAT_ACCEPTED: n_accepted++;
                    mbcrc_pkg::STAT_CRC_ERR:  n_crc_err++;
                    mbcrc_pkg::STAT_NOT_ADDR: n_not_addr++;
                    default: ;
                endcase
            end
        end
    end

    // ------------------------------------------------------------------
    // Watchdog: any accepted transaction on either channel or the APB port
    // restarts the count
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            quiet_cycles <= 0;
        end else if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
                     (psel && penable)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus sequence
    // ------------------------------------------------------------------
    initial begin
        int          sent;
        int          roll;
        logic [7:0]  setting;
        t_frame_kind kind;

        in_ch.valid     = 1'b0;
        in_ch.data_byte = 8'h00;
        in_ch.frame_end = 1'b0;
        in_ch.operation = OP_SEND;
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
        paddr   = 3'b000;
        pwdata  = 32'h0;
        n_bytes = 0;
        n_results = 0;
        n_accepted = 0;
        n_crc_err = 0;
        n_not_addr = 0;
        n_bad = 0;
        n_other_fail = 0;

        repeat (12) @(negedge i_clk);
        i_rst_n = 1'b1;
        station_addr = mbcrc_pkg::OWN_ADDR_RESET;
        clear_frame_state();

        // directed part, station address still at its reset value
        foreach (DIR_ROWS[r]) begin
            offer_byte(t_rtu_byte'{DIR_ROWS[r].data, DIR_ROWS[r].last, DIR_ROWS[r].op},
                       DIR_ROWS[r].pinned, t_rtu_result'{8'h00, 1'b1, DIR_ROWS[r].status});
        end
        settle_block();

        // random phases, each under its own station address
        for (int phase = 0; phase < NUM_PHASES; phase++) begin
            setting = (phase == NUM_PHASES - 1) ? 8'($urandom) : STATION_SET[phase];
            program_station(ADDR_OWN, setting);
            if (phase == 2) begin
                program_station(ADDR_UNMAPPED, 8'($urandom));   // must leave own_address alone
            end
            calm = (phase == 1 || phase == 3);
            if (phase == 1) begin
                hold_req = 1'b1;   // back-to-back send frames against a stalled receiver
            end
            sent = 0;
            while (sent < ITEMS_PER_PHASE) begin
                roll = $urandom_range(0, 99);
                if (phase == 1 || (roll >= 45 && roll < 75)) begin
                    kind = FR_SEND;
                end else if (roll < 45) begin
                    kind = FR_GOOD_CHECK;
                end else begin
                    kind = FR_NOISE;
                end
                build_frame(kind);
                foreach (frame_bytes[k]) offer_byte(frame_bytes[k], 1'b0, t_rtu_result'('0));
                sent += frame_bytes.size();
            end
            settle_block();
        end

        $display("Ran %0d frame bytes under %0d station addresses, %0d results checked:",
                 n_bytes, NUM_PHASES + 1, n_results);
        $display("  %0d frames accepted, %0d CRC errors, %0d not addressed here",
                 n_accepted, n_crc_err, n_not_addr);
        if (n_bad == 0 && n_other_fail == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

### sim.f
+incdir+design
design/mbcrc_pkg.sv
design/mbcrc_if.sv
design/mbcrc_front.sv
design/mbcrc_fifo.sv
design/mbcrc_back.sv
design/modbus_rtu_frame_crc_core.sv
bench/tb_modbus_rtu_frame_crc_core.sv
